[design/utu_pkg.sv]
// utu_pkg: shared types and constants of the utf-8 to utf-16 stream unit
// used by utu_decode and utf8_to_utf16_stream_unit; no dependencies

package utu_pkg;

   localparam int unsigned CapWidth   = 12;
   localparam int unsigned CodeWidth  = 21;
   localparam int unsigned UnitWidth  = 16;
   localparam int unsigned MaxResults = 3;

   localparam logic [CapWidth-1:0] CAPACITY_RESET = 12'd96;

   localparam logic [7:0] MASK_TOP2   = 8'hC0;
   localparam logic [7:0] MASK_TOP3   = 8'hE0;
   localparam logic [7:0] MASK_TOP4   = 8'hF0;
   localparam logic [7:0] MASK_TOP5   = 8'hF8;
   localparam logic [7:0] TAG_CONT    = 8'h80;
   localparam logic [7:0] TAG_LEAD2   = 8'hC0;
   localparam logic [7:0] TAG_LEAD3   = 8'hE0;
   localparam logic [7:0] TAG_LEAD4   = 8'hF0;
   localparam logic [7:0] ASCII_LIMIT = 8'h80;

   localparam logic [CodeWidth-1:0] BMP_MAX      = 21'h00FFFF;
   localparam logic [CodeWidth-1:0] SUPPL_OFFSET = 21'h010000;
   localparam logic [UnitWidth-1:0] HIGH_SURR    = 16'hD800;
   localparam logic [UnitWidth-1:0] LOW_SURR     = 16'hDC00;

   // csr register index
   localparam logic REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic [CodeWidth-1:0] partial_code;
      logic [1:0]           bytes_pending;
      logic [CapWidth-1:0]  units_written;
      logic                 output_stopped;
      logic                 string_ended;
   } state_type;

   typedef struct packed {
      logic [UnitWidth-1:0] code_unit;
      logic                 end_of_text;
      logic [CapWidth-1:0]  unit_count;
      logic                 terminator_fits;
   } result_type;

   localparam state_type STATE_RESET = '{
      partial_code:   '0,
      bytes_pending:  2'd0,
      units_written:  '0,
      output_stopped: 1'b0,
      string_ended:   1'b0
   };

endpackage

[design/utu_decode.sv]
// utu_decode: one-byte decode step, next sequence state and up to three results
// depends on utu_pkg

module utu_decode (
   input  utu_pkg::state_type                 state_i,
   input  logic [7:0]                         in_byte,
   input  logic                               last_byte,
   input  logic [utu_pkg::CapWidth-1:0]       capacity,
   output utu_pkg::state_type                 state_o,
   output utu_pkg::result_type                results [utu_pkg::MaxResults],
   output logic [1:0]                         num_results
);

   utu_pkg::state_type               st;
   utu_pkg::result_type              res [utu_pkg::MaxResults];
   logic [1:0]                       n;
   logic                             emit;
   logic [utu_pkg::CodeWidth-1:0]    cp;
   logic [utu_pkg::CodeWidth-1:0]    cp_off;
   logic [utu_pkg::CodeWidth-1:0]    pc_shift;

   always_comb begin
      st       = state_i;
      n        = 2'd0;
      emit     = 1'b0;
      cp       = '0;
      cp_off   = '0;
      pc_shift = '0;
      for (int i = 0; i < int'(utu_pkg::MaxResults); i++) begin
         res[i] = '0;
      end

      if (st.string_ended) begin
         st = utu_pkg::STATE_RESET;
      end

      if (in_byte != 8'h00) begin
         if ((in_byte & utu_pkg::MASK_TOP2) == utu_pkg::TAG_CONT) begin
            if (st.bytes_pending != 2'd0) begin
               pc_shift         = {st.partial_code[utu_pkg::CodeWidth-7:0], in_byte[5:0]};
               st.partial_code  = pc_shift;
               st.bytes_pending = st.bytes_pending - 2'd1;
               if (st.bytes_pending == 2'd0) begin
                  emit            = 1'b1;
                  cp              = pc_shift;
                  st.partial_code = '0;
               end
            end
         end else begin
            st.bytes_pending = 2'd0;
            st.partial_code  = '0;
            if (in_byte < utu_pkg::ASCII_LIMIT) begin
               emit = 1'b1;
               cp   = {{(utu_pkg::CodeWidth-8){1'b0}}, in_byte};
            end else if ((in_byte & utu_pkg::MASK_TOP3) == utu_pkg::TAG_LEAD2) begin
               st.partial_code  = {{(utu_pkg::CodeWidth-5){1'b0}}, in_byte[4:0]};
               st.bytes_pending = 2'd1;
            end else if ((in_byte & utu_pkg::MASK_TOP4) == utu_pkg::TAG_LEAD3) begin
               st.partial_code  = {{(utu_pkg::CodeWidth-4){1'b0}}, in_byte[3:0]};
               st.bytes_pending = 2'd2;
            end else if ((in_byte & utu_pkg::MASK_TOP5) == utu_pkg::TAG_LEAD4) begin
               st.partial_code  = {{(utu_pkg::CodeWidth-3){1'b0}}, in_byte[2:0]};
               st.bytes_pending = 2'd3;
            end
         end
      end

      if (emit) begin
         if (st.output_stopped || (st.units_written >= capacity)) begin
            st.output_stopped = 1'b1;
         end else if (cp <= utu_pkg::BMP_MAX) begin
            st.units_written      = st.units_written + 12'd1;
            res[0].code_unit      = cp[utu_pkg::UnitWidth-1:0];
            res[0].unit_count     = st.units_written;
            n                     = 2'd1;
         end else if (({1'b0, st.units_written} + 13'd2) > {1'b0, capacity}) begin
            st.output_stopped = 1'b1;
         end else begin
            cp_off            = cp - utu_pkg::SUPPL_OFFSET;
            st.units_written  = st.units_written + 12'd1;
            res[0].code_unit  = utu_pkg::HIGH_SURR + {5'b0, cp_off[20:10]};
            res[0].unit_count = st.units_written;
            st.units_written  = st.units_written + 12'd1;
            res[1].code_unit  = utu_pkg::LOW_SURR + {6'b0, cp_off[9:0]};
            res[1].unit_count = st.units_written;
            n                 = 2'd2;
         end
      end

      if ((in_byte == 8'h00) || last_byte) begin
         st.partial_code          = '0;
         st.bytes_pending         = 2'd0;
         res[n].code_unit         = '0;
         res[n].end_of_text       = 1'b1;
         res[n].unit_count        = st.units_written;
         res[n].terminator_fits   = (st.units_written < capacity);
         n                        = n + 2'd1;
         st.string_ended          = 1'b1;
      end
   end

   assign state_o     = st;
   assign results     = res;
   assign num_results = n;

endmodule

[design/utf8_to_utf16_stream_unit.sv]
// utf8_to_utf16_stream_unit: streaming utf-8 to utf-16 transcoder top level
// depends on utu_pkg and utu_decode
//
//   channel   ports                         direction  transaction
//   req       req_valid/ready, byte, last   in         one utf-8 byte
//   rsp       rsp_valid/ready, unit fields  out        one code unit or end summary
//   csr       apb-style, capacity at 0x0    in         register write/read
//
// a byte is registered, then decoded combinationally into a result buffer of up to three entries
// one byte per cycle while rsp_ready is high and each byte gives at most one result; a byte
// with k results holds the buffer until all k are handed off; a byte passes the s1 register,
// then the buffer; the next byte is taken while the last buffered result is handed off
// synchronous active-high reset clears sequence state, buffers and sets capacity to 96

module utf8_to_utf16_stream_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_end_of_text,
   output logic [11:0] rsp_unit_count,
   output logic        rsp_terminator_fits,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [utu_pkg::CapWidth-1:0] capacity_ff;
   utu_pkg::state_type           state_ff;
   utu_pkg::state_type           state_in;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   utu_pkg::result_type buf_ff [utu_pkg::MaxResults];
   utu_pkg::result_type buf_in [utu_pkg::MaxResults];
   logic [1:0]          num_ff;
   logic [1:0]          num_in;
   logic [1:0]          rd_ff;

   logic pop;
   logic buf_free;
   logic load;
   logic csr_write;

   utu_decode u_decode (
      .state_i     (state_ff),
      .in_byte     (s1_byte_ff),
      .last_byte   (s1_last_ff),
      .capacity    (capacity_ff),
      .state_o     (state_in),
      .results     (buf_in),
      .num_results (num_in)
   );

   assign rsp_valid = (rd_ff != num_ff);
   assign pop       = rsp_valid && rsp_ready;
   assign buf_free  = !rsp_valid || (pop && ((rd_ff + 2'd1) == num_ff));
   assign load      = s1_valid_ff && buf_free;
   assign req_ready = !s1_valid_ff || load;

   assign rsp_code_unit       = buf_ff[rd_ff].code_unit;
   assign rsp_end_of_text     = buf_ff[rd_ff].end_of_text;
   assign rsp_unit_count      = buf_ff[rd_ff].unit_count;
   assign rsp_terminator_fits = buf_ff[rd_ff].terminator_fits;

   assign csr_write = psel && penable && pwrite && (paddr[2] == utu_pkg::REG_CAPACITY);
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == utu_pkg::REG_CAPACITY) ?
                      {{(32-utu_pkg::CapWidth){1'b0}}, capacity_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= utu_pkg::CAPACITY_RESET;
      end else if (csr_write) begin
         capacity_ff <= pwdata[utu_pkg::CapWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_in_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= utu_pkg::STATE_RESET;
         num_ff   <= 2'd0;
         rd_ff    <= 2'd0;
      end else if (load) begin
         state_ff <= state_in;
         num_ff   <= num_in;
         rd_ff    <= 2'd0;
      end else if (pop) begin
         rd_ff <= rd_ff + 2'd1;
      end
      if (load) begin
         buf_ff <= buf_in;
      end
   end

endmodule

[design/utu_checker.sv]
// utu_port_checker: port-level assertions for utf8_to_utf16_stream_unit
// bound to the top level; no package dependencies

module utu_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_code_unit,
   input logic        rsp_end_of_text,
   input logic [11:0] rsp_unit_count,
   input logic        rsp_terminator_fits
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_unit)
         && $stable(rsp_unit_count))
      else $error("rsp transaction changed while stalled");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_text |-> rsp_code_unit == 16'd0)
      else $error("end transaction carries nonzero code unit");

   a_unit_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_text |-> !rsp_terminator_fits && rsp_unit_count != 12'd0)
      else $error("unit transaction has bad count or fits flag");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind utf8_to_utf16_stream_unit utu_port_checker u_utu_port_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_code_unit       (rsp_code_unit),
   .rsp_end_of_text     (rsp_end_of_text),
   .rsp_unit_count      (rsp_unit_count),
   .rsp_terminator_fits (rsp_terminator_fits)
);

[tb/utu_checker.sv]
// utu_checker: watches the byte, unit and csr channels of the utf-8 to utf-16 unit,
// predicts every code unit and end summary and compares them in order
// depends on utu_pkg

module utu_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_code_unit,
   input  logic        rsp_end_of_text,
   input  logic [11:0] rsp_unit_count,
   input  logic        rsp_terminator_fits,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          fail_count,
   output int          units_pending,
   output int          units_checked,
   output int          ends_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CAPACITY_ADDR = {utu_pkg::REG_CAPACITY, 2'b00};

   logic [utu_pkg::CapWidth-1:0] capacity;
   utu_pkg::state_type           dec;
   utu_pkg::result_type          expected_units[$];

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("utu_checker: %0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic void queue_result(input logic [utu_pkg::UnitWidth-1:0] unit,
                                        input logic eot, input logic fits);
      utu_pkg::result_type r;
      r.code_unit       = unit;
      r.end_of_text     = eot;
      r.unit_count      = dec.units_written;
      r.terminator_fits = fits;
      expected_units.push_back(r);
   endfunction

   function automatic void emit_value(input logic [utu_pkg::CodeWidth-1:0] cp);
      logic [utu_pkg::CodeWidth-1:0] offs;
      if (dec.output_stopped || dec.units_written >= capacity) begin
         dec.output_stopped = 1'b1;
         return;
      end
      if (cp <= utu_pkg::BMP_MAX) begin
         dec.units_written = dec.units_written + 12'd1;
         queue_result(cp[utu_pkg::UnitWidth-1:0], 1'b0, 1'b0);
         return;
      end
      // surrogate pair goes out whole or not at all
      if (({1'b0, dec.units_written} + 13'd2) > {1'b0, capacity}) begin
         dec.output_stopped = 1'b1;
         return;
      end
      offs = cp - utu_pkg::SUPPL_OFFSET;
      dec.units_written = dec.units_written + 12'd1;
      queue_result(utu_pkg::HIGH_SURR + {5'b0, offs[20:10]}, 1'b0, 1'b0);
      dec.units_written = dec.units_written + 12'd1;
      queue_result(utu_pkg::LOW_SURR + {6'b0, offs[9:0]}, 1'b0, 1'b0);
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic last);
      if (dec.string_ended) begin
         dec = utu_pkg::STATE_RESET;
      end
      if (b != 8'h00) begin
         if ((b & utu_pkg::MASK_TOP2) == utu_pkg::TAG_CONT) begin
            if (dec.bytes_pending != 2'd0) begin
               dec.partial_code  = {dec.partial_code[utu_pkg::CodeWidth-7:0], b[5:0]};
               dec.bytes_pending = dec.bytes_pending - 2'd1;
               if (dec.bytes_pending == 2'd0) begin
                  emit_value(dec.partial_code);
                  dec.partial_code = '0;
               end
            end
         end else begin
            dec.bytes_pending = 2'd0;
            dec.partial_code  = '0;
            if (b < utu_pkg::ASCII_LIMIT) begin
               emit_value({13'b0, b});
            end else if ((b & utu_pkg::MASK_TOP3) == utu_pkg::TAG_LEAD2) begin
               dec.partial_code  = {16'b0, b[4:0]};
               dec.bytes_pending = 2'd1;
            end else if ((b & utu_pkg::MASK_TOP4) == utu_pkg::TAG_LEAD3) begin
               dec.partial_code  = {17'b0, b[3:0]};
               dec.bytes_pending = 2'd2;
            end else if ((b & utu_pkg::MASK_TOP5) == utu_pkg::TAG_LEAD4) begin
               dec.partial_code  = {18'b0, b[2:0]};
               dec.bytes_pending = 2'd3;
            end
         end
      end
      if (b == 8'h00 || last) begin
         dec.partial_code  = '0;
         dec.bytes_pending = 2'd0;
         queue_result('0, 1'b1, dec.units_written < capacity);
         dec.string_ended = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      utu_pkg::result_type want;
      if (reset) begin
         capacity = utu_pkg::CAPACITY_RESET;
         dec      = utu_pkg::STATE_RESET;
         expected_units.delete();
         fail_count    = 0;
         units_pending = 0;
         units_checked = 0;
         ends_checked  = 0;
      end else begin
         if (psel && penable && pready && paddr == CAPACITY_ADDR) begin
            if (pwrite) begin
               capacity = pwdata[utu_pkg::CapWidth-1:0];
            end else if (prdata !== 32'(capacity)) begin
               report("capacity read", prdata, 32'(capacity));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_units.size() == 0) begin
               report("unexpected transaction code_unit", 32'(rsp_code_unit), 32'h0);
            end else begin
               want = expected_units.pop_front();
               if (rsp_code_unit !== want.code_unit)
                  report("code_unit", 32'(rsp_code_unit), 32'(want.code_unit));
               if (rsp_end_of_text !== want.end_of_text)
                  report("end_of_text", 32'(rsp_end_of_text), 32'(want.end_of_text));
               if (rsp_unit_count !== want.unit_count)
                  report("unit_count", 32'(rsp_unit_count), 32'(want.unit_count));
               if (rsp_terminator_fits !== want.terminator_fits)
                  report("terminator_fits", 32'(rsp_terminator_fits),
                         32'(want.terminator_fits));
               if (want.end_of_text) begin
                  ends_checked++;
               end else begin
                  units_checked++;
               end
            end
         end
         if (req_valid && req_ready) begin
            decode_byte(req_in_byte, req_last_byte);
         end
         units_pending = expected_units.size();
      end
   end

endmodule

[tb/testbench.sv]
// testbench: directed and random utf-8 strings into utf8_to_utf16_stream_unit under
// several capacity settings, with random stalls on both channels
// depends on utu_pkg, utu_checker and the unit itself

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CAPACITY_ADDR = {utu_pkg::REG_CAPACITY, 2'b00};
   localparam int         PHASES        = 12;
   localparam int         PHASE_BYTES   = 26;

   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte         = 8'h00;
   logic        req_last_byte       = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready           = 1'b0;
   logic [15:0] rsp_code_unit;
   logic        rsp_end_of_text;
   logic [11:0] rsp_unit_count;
   logic        rsp_terminator_fits;
   logic        psel                = 1'b0;
   logic        penable             = 1'b0;
   logic        pwrite              = 1'b0;
   logic [2:0]  paddr               = 3'd0;
   logic [31:0] pwdata              = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   int fail_count;
   int units_pending;
   int units_checked;
   int ends_checked;

   bit          calm       = 1'b0;
   int          stall_left = 0;
   int          bytes_sent = 0;
   logic [8:0]  octets[$];

   utf8_to_utf16_stream_unit DUT (.*);

   utu_checker unit_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   always @(negedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_string();
      logic [8:0] o;
      while (octets.size() != 0) begin
         o = octets.pop_front();
         send_byte(o[7:0], o[8]);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (units_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= CAPACITY_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic void append_char(input int unsigned cp, input int unsigned len);
      logic [20:0] c;
      c = cp[20:0];
      unique case (len)
         1: octets.push_back({1'b0, 1'b0, c[6:0]});
         2: begin
            octets.push_back({1'b0, utu_pkg::TAG_LEAD2 | {3'b0, c[10:6]}});
            octets.push_back({1'b0, utu_pkg::TAG_CONT | {2'b0, c[5:0]}});
         end
         3: begin
            octets.push_back({1'b0, utu_pkg::TAG_LEAD3 | {4'b0, c[15:12]}});
            octets.push_back({1'b0, utu_pkg::TAG_CONT | {2'b0, c[11:6]}});
            octets.push_back({1'b0, utu_pkg::TAG_CONT | {2'b0, c[5:0]}});
         end
         default: begin
            octets.push_back({1'b0, utu_pkg::TAG_LEAD4 | {5'b0, c[20:18]}});
            octets.push_back({1'b0, utu_pkg::TAG_CONT | {2'b0, c[17:12]}});
            octets.push_back({1'b0, utu_pkg::TAG_CONT | {2'b0, c[11:6]}});
            octets.push_back({1'b0, utu_pkg::TAG_CONT | {2'b0, c[5:0]}});
         end
      endcase
   endfunction

   function automatic int unsigned pick_value(input int unsigned len);
      int unsigned edges[4];
      edges = '{32'h0FFFF, 32'h10000, 32'h10FFFF, 32'h1FFFFF};
      unique case (len)
         1: return $urandom_range(1, 8'h7F);
         2: return $urandom_range(0, 11'h7FF);
         3: return $urandom_range(0, 16'hFFFF);
         default: begin
            if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 3)];
            return $urandom_range(0, 21'h1FFFFF);
         end
      endcase
   endfunction

   task automatic build_string();
      int unsigned pick;
      int unsigned len;
      logic [8:0]  tail;
      repeat ($urandom_range(1, 10)) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            len = $urandom_range(1, 4);
            append_char(pick_value(len), len);
         end else if (pick < 68) begin
            octets.push_back({1'b0, 8'($urandom_range(8'h80, 8'hBF))});
         end else if (pick < 74) begin
            octets.push_back({1'b0, 8'($urandom_range(8'hF8, 8'hFF))});
         end else if (pick < 88) begin
            // truncated sequence, broken by whatever follows
            len = $urandom_range(2, 4);
            append_char(pick_value(len), len);
            repeat ($urandom_range(1, len - 1)) tail = octets.pop_back();
         end else begin
            octets.push_back({1'b0, 8'($urandom_range(1, 255))});
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         tail = octets.pop_back();
         octets.push_back({1'b1, tail[7:0]});
      end else if (pick < 88) begin
         octets.push_back({1'($urandom_range(0, 1)), 8'h00});
      end
   endtask

   initial begin
      int unsigned fixed_caps[6];
      int unsigned cap_value;
      int          phase_bytes;
      fixed_caps = '{0, 1, 2, 3, 4095, 2};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_access(1'b0, 32'h0);

      // ascii, two, three and four byte forms, overlong, largest value
      octets = '{9'h041, 9'h07F, 9'h0C3, 9'h0A9, 9'h0C0, 9'h080, 9'h0E2, 9'h082, 9'h0AC,
                 9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF};
      // stray continuation, invalid lead, broken sequence, zero end
      octets.push_back(9'h080);
      octets.push_back(9'h0FF);
      octets.push_back(9'h0C3);
      octets.push_back(9'h041);
      octets.push_back(9'h000);
      // end with a sequence still open
      octets.push_back(9'h0E2);
      octets.push_back(9'h182);
      send_string();

      for (int i = 0; i < PHASES; i++) begin
         if (i >= PHASES - 2) calm = 1'b1;
         cap_value = (i < 6) ? fixed_caps[i] : $urandom_range(1, 24);
         settle();
         csr_access(1'b1, cap_value);
         csr_access(1'b0, 32'h0);
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            build_string();
            phase_bytes += octets.size();
            send_string();
         end
      end

      settle();
      repeat (8) @(negedge clock);
      $display("summary: %0d bytes sent over %0d capacity settings", bytes_sent, PHASES + 1);
      $display("summary: %0d code units and %0d string ends compared",
               units_checked, ends_checked);
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
design/utu_pkg.sv
design/utu_decode.sv
design/utf8_to_utf16_stream_unit.sv
design/utu_checker.sv
tb/utu_checker.sv
tb/testbench.sv
